FILE: design/clpd_pkg.sv
// ----------------------------------------------------------------------------
// clpd_pkg
// Shared types and constants for the closest pair distance block: payload
// structs, controller command and status bundles, and datapath widths.
// ----------------------------------------------------------------------------
package clpd_pkg;

    // point store capacity
    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // coordinate and result widths
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int BEST_W  = 50;
    localparam int DIST_W  = BEST_W / 2;
    localparam int REM_W   = DIST_W + 3;
    localparam int ROOT_STEPS = BEST_W / 2;
    localparam int STEP_W  = $clog2(ROOT_STEPS);

    // input item
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [DIST_W-1:0] min_distance;
        logic              too_few_points;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_step;
        logic sqrt_start;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic pipe_empty;
        logic last;
        logic few;
        logic sqrt_last;
        logic out_busy;
    } t_stat;

endpackage

FILE: design/clpd_ctrl.sv
// ----------------------------------------------------------------------------
// clpd_ctrl
// Controller state machine: takes a point, scans over the stored points, runs
// the square root when a set of two or more closes and hands over the result.
// ----------------------------------------------------------------------------
module clpd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  clpd_pkg::t_stat i_stat,
    output clpd_pkg::t_cmd  o_cmd
);
    import clpd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SQRT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = !i_stat.scan_done;
                if (i_stat.scan_done && i_stat.pipe_empty) begin
                    priority if (!i_stat.last) begin
                        n_state = S_IDLE;
                    end else if (i_stat.few) begin
                        n_state = S_OUT;
                    end else begin
                        o_cmd.sqrt_start = 1'b1;
                        n_state          = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_stat.sqrt_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/clpd_dpath.sv
// ----------------------------------------------------------------------------
// clpd_dpath
// Datapath: point store, pipelined squared distance and running minimum,
// digit-by-digit square root and the result register.
// ----------------------------------------------------------------------------
module clpd_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clpd_pkg::t_in_item  i_in_data,
    input  clpd_pkg::t_cmd      i_cmd,
    output clpd_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output clpd_pkg::t_out_item o_out_data
);
    import clpd_pkg::*;

    // point store, x in the upper half
    logic [2*COORD_W-1:0] r_mem [MAX_POINTS];
    logic [2*COORD_W-1:0] r_rd_data;

    // current point and set bookkeeping
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic                      r_last;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_scan_idx;
    logic [CNT_W-1:0]          r_scan_lim;

    // distance pipeline
    logic              r_v0;
    logic              r_v1;
    logic              r_v2;
    logic [COORD_W-1:0] r_dx;
    logic [COORD_W-1:0] r_dy;
    logic [SQ_W-1:0]    r_sqx;
    logic [SQ_W-1:0]    r_sqy;
    logic [BEST_W-1:0]  r_best;

    // square root
    logic [BEST_W-1:0] r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [DIST_W-1:0] r_root;
    logic [STEP_W-1:0] r_step;

    // result register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic signed [DIFF_W-1:0] n_diff_x;
    logic signed [DIFF_W-1:0] n_diff_y;
    logic [DIFF_W-1:0]        n_mag_x;
    logic [DIFF_W-1:0]        n_mag_y;
    logic [SUM_W-1:0]         n_sum;
    logic [REM_W-1:0]         n_rem_sh;
    logic [REM_W-1:0]         n_trial;
    logic                     n_few;

    // store write on load, registered read during the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CNT_W'(MAX_POINTS))) begin
            r_mem[r_count[ADDR_W-1:0]] <= {i_in_data.point_x, i_in_data.point_y};
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= r_mem[r_scan_idx[ADDR_W-1:0]];
        end
    end

    // current point payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_in_data.point_x;
            r_py <= i_in_data.point_y;
        end
    end

    // set bookkeeping and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_scan_idx <= '0;
            r_scan_lim <= '0;
            r_last     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_scan_idx <= '0;
                r_scan_lim <= r_count;
                r_last     <= i_in_data.last_point;
                if (r_count < CNT_W'(MAX_POINTS)) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (i_cmd.scan_step) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_count <= '0;
            end
        end
    end

    // absolute coordinate differences
    always_comb begin
        n_diff_x = DIFF_W'(r_px) - DIFF_W'($signed(r_rd_data[2*COORD_W-1:COORD_W]));
        n_diff_y = DIFF_W'(r_py) - DIFF_W'($signed(r_rd_data[COORD_W-1:0]));
        n_mag_x  = n_diff_x[DIFF_W-1] ? DIFF_W'(-n_diff_x) : DIFF_W'(n_diff_x);
        n_mag_y  = n_diff_y[DIFF_W-1] ? DIFF_W'(-n_diff_y) : DIFF_W'(n_diff_y);
        n_sum    = {1'b0, r_sqx} + {1'b0, r_sqy};
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.scan_step;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // difference and square stages
    always_ff @(posedge i_clk) begin
        r_dx  <= n_mag_x[COORD_W-1:0];
        r_dy  <= n_mag_y[COORD_W-1:0];
        r_sqx <= r_dx * r_dx;
        r_sqy <= r_dy * r_dy;
    end

    // running minimum of the squared distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '1;
        end else if (i_cmd.out_load) begin
            r_best <= '1;
        end else if (r_v2 && (BEST_W'(n_sum) < r_best)) begin
            r_best <= BEST_W'(n_sum);
        end
    end

    // one root bit per step
    always_comb begin
        n_rem_sh = {r_rem[REM_W-3:0], r_rad[BEST_W-1 -: 2]};
        n_trial  = {1'b0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.sqrt_start) begin
            r_step <= STEP_W'(ROOT_STEPS - 1);
        end else if (i_cmd.sqrt_step && (r_step != '0)) begin
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_rad  <= r_best;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[BEST_W-3:0], 2'b00};
            if (n_rem_sh >= n_trial) begin
                r_rem  <= n_rem_sh - n_trial;
                r_root <= {r_root[DIST_W-2:0], 1'b1};
            end else begin
                r_rem  <= n_rem_sh;
                r_root <= {r_root[DIST_W-2:0], 1'b0};
            end
        end
    end

    assign n_few = r_count < CNT_W'(2);

    // result register, freed by an output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.min_distance   <= n_few ? '0 : r_root;
            r_out_data.too_few_points <= n_few;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.scan_done  = (r_scan_idx == r_scan_lim);
        o_stat.pipe_empty = !(r_v0 || r_v1 || r_v2);
        o_stat.last       = r_last;
        o_stat.few        = n_few;
        o_stat.sqrt_last  = (r_step == '0);
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: design/closest_pair_distance.sv
// A point is taken only while idle; the scan then reads every point stored before it and
// drains the distance pipeline before the next point is taken. The final point of a set
// then adds the square root, skipped for fewer than two points, and the result load,
// which a held result stalls. Point rate is bounded by the single read port of the store.
// Reset: synchronous active low; clears the point count and sets the minimum to all ones.
// The point store is not cleared; only entries already written in the set are read.
// ----------------------------------------------------------------------------
// closest_pair_distance
// Smallest Euclidean distance within a set of 2D fixed-point points, found by
// comparing each new point with every stored point, followed by a floor root.
// ----------------------------------------------------------------------------
module closest_pair_distance (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  clpd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output clpd_pkg::t_out_item o_out_data
);
    import clpd_pkg::*;

    t_cmd  s_cmd;
    t_stat s_stat;

    // controller
    clpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    // datapath
    clpd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // a transfer in always starts a scan
    a_accept_leaves_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready
    ) else $error("input taken while a point is still in work");

    // a result is loaded only once every comparison has retired
    a_result_after_scan: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |-> (s_stat.scan_done && s_stat.pipe_empty)
    ) else $error("result loaded with comparisons outstanding");

    // output valid rises only from a result load
    a_out_from_load: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(s_cmd.out_load)
    ) else $error("output valid without a result load");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for closest_pair_distance. A short list of directed point sets is
// followed by random sets and one set that overruns the point store. Every
// transfer in feeds a behavioral model of the minimum distance search, and
// each result transfer is checked field by field against the oldest
// prediction. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import clpd_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam int          DRAIN_CYCLES  = 64;
    localparam int          RANDOM_POINTS = 450;

    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    // one directed stimulus row, with an optional typed-in result
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_point_row;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;

    // model state: points of the open set and the smallest squared distance
    logic signed [COORD_W-1:0] set_x [MAX_POINTS];
    logic signed [COORD_W-1:0] set_y [MAX_POINTS];
    int                        set_count;
    logic [BEST_W-1:0]         nearest_sq;

    t_out_item   pending_distances[$];
    t_point_row  directed_rows[$];
    int          mismatch_count;
    int unsigned cycle_count;
    int          burst_left;
    int          ready_left;
    bit          ready_phase;

    always #5 clk = ~clk;

    closest_pair_distance dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // floor square root, one result bit at a time from the top
    function automatic logic [DIST_W-1:0] floor_root(logic [BEST_W-1:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        root = '0;
        for (b = DIST_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= {14'd0, v}) begin
                root = trial;
            end
        end
        return root[DIST_W-1:0];
    endfunction

    // fold one point into the open set; returns 1 when the point closes it
    function automatic bit predict_distance(input t_in_item it, output t_out_item res);
        int                i;
        longint            dx;
        longint            dy;
        logic [BEST_W-1:0] d2;
        res = '0;
        for (i = 0; i < set_count; i++) begin
            dx = longint'(it.point_x) - longint'(set_x[i]);
            dy = longint'(it.point_y) - longint'(set_y[i]);
            if (dx < 0) begin
                dx = -dx;
            end
            if (dy < 0) begin
                dy = -dy;
            end
            d2 = BEST_W'(dx * dx + dy * dy);
            if (d2 < nearest_sq) begin
                nearest_sq = d2;
            end
        end
        // points beyond capacity are compared but not kept
        if (set_count < MAX_POINTS) begin
            set_x[set_count] = it.point_x;
            set_y[set_count] = it.point_y;
            set_count++;
        end
        if (!it.last_point) begin
            return 1'b0;
        end
        if (set_count < 2) begin
            res.min_distance   = '0;
            res.too_few_points = 1'b1;
        end else begin
            res.min_distance   = floor_root(nearest_sq);
            res.too_few_points = 1'b0;
        end
        set_count  = 0;
        nearest_sq = '1;
        return 1'b1;
    endfunction

    function automatic logic signed [COORD_W-1:0] corner_coord();
        case ($urandom_range(0, 3))
            0: begin
                return COORD_MIN;
            end
            1: begin
                return COORD_MAX;
            end
            2: begin
                return '0;
            end
            default: begin
                return '1;
            end
        endcase
    endfunction

    // mostly points clustered around the set center, some anywhere, some corners
    function automatic t_in_item rand_point(logic signed [COORD_W-1:0] cx,
                                            logic signed [COORD_W-1:0] cy, bit last);
        t_in_item p;
        int       style;
        style = $urandom_range(0, 9);
        if (style < 6) begin
            p.point_x = cx + COORD_W'(int'($urandom_range(0, 1024)) - 512);
            p.point_y = cy + COORD_W'(int'($urandom_range(0, 1024)) - 512);
        end else if (style < 9) begin
            p.point_x = COORD_W'($urandom);
            p.point_y = COORD_W'($urandom);
        end else begin
            p.point_x = corner_coord();
            p.point_y = corner_coord();
        end
        p.last_point = last;
        return p;
    endfunction

    task automatic add_row(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                           bit last, bit typed, logic [DIST_W-1:0] want_dist, bit few);
        t_point_row r;
        r.item.point_x          = x;
        r.item.point_y          = y;
        r.item.last_point       = last;
        r.typed                 = typed;
        r.want.min_distance     = want_dist;
        r.want.too_few_points   = few;
        directed_rows.push_back(r);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %0s: got %0d, expected %0d, cycle %0d",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // drive one point in bursts with random gaps, then run the model on it
    task automatic send_point(input t_in_item it, output bit closes, output t_out_item res);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do begin
            @(posedge clk);
        end while (!in_ready);
        burst_left--;
        closes = predict_distance(it, res);
    endtask

    // result side: check each transfer, then pick the next ready level
    always @(posedge clk) begin : result_side
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_distances.size() == 0) begin
                report_mismatch("result with nothing pending",
                                longint'(out_data.min_distance), longint'(0));
            end else begin
                want = pending_distances.pop_front();
                if (out_data.min_distance !== want.min_distance) begin
                    report_mismatch("min_distance", longint'(out_data.min_distance),
                                    longint'(want.min_distance));
                end
                if (out_data.too_few_points !== want.too_few_points) begin
                    report_mismatch("too_few_points", longint'(out_data.too_few_points),
                                    longint'(want.too_few_points));
                end
            end
        end
        if (ready_left > 0) begin
            ready_left--;
        end else begin
            ready_phase = !ready_phase;
            if (ready_phase) begin
                ready_left = $urandom_range(1, 40);
            end else if ($urandom_range(0, 3) == 0) begin
                ready_left = $urandom_range(10, 30);
            end else begin
                ready_left = $urandom_range(0, 5);
            end
        end
        out_ready <= ready_phase;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** closest_pair_distance: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item                  it;
        t_out_item                 res;
        bit                        closes;
        int                        random_sent;
        int                        set_size;
        int                        k;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        t_in_item                  anchor;
        t_in_item                  far_point;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        set_count      = 0;
        nearest_sq     = '1;
        burst_left     = 0;
        ready_left     = 0;
        ready_phase    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed sets:    x           y          last typed dist      few
        add_row('0,        '0,        1'b1, 1'b1, '0,        1'b1); // lone point
        add_row(COORD_MAX, COORD_MAX, 1'b0, 1'b0, '0,        1'b0); // opposite corners
        add_row(COORD_MIN, COORD_MIN, 1'b1, 1'b0, '0,        1'b0);
        add_row('0,        '0,        1'b0, 1'b0, '0,        1'b0); // 3-4-5 scaled by 256, distance 1280
        add_row(24'sd768,  24'sd1024, 1'b1, 1'b1, 25'd1280,  1'b0);
        add_row(24'sd100,  -24'sd200, 1'b0, 1'b0, '0,        1'b0); // coincident pair
        add_row(24'sd100,  -24'sd200, 1'b1, 1'b1, '0,        1'b0);
        add_row(COORD_MIN, COORD_MAX, 1'b0, 1'b0, '0,        1'b0); // other diagonal
        add_row(COORD_MAX, COORD_MIN, 1'b0, 1'b0, '0,        1'b0);
        add_row('0,        '0,        1'b1, 1'b0, '0,        1'b0);
        add_row(-24'sd1,   -24'sd1,   1'b0, 1'b0, '0,        1'b0); // one lsb apart
        add_row('0,        '0,        1'b0, 1'b0, '0,        1'b0);
        add_row(24'sd1,    '0,        1'b0, 1'b0, '0,        1'b0);
        add_row(24'sd5,    24'sd5,    1'b1, 1'b0, '0,        1'b0);
        add_row(COORD_MAX, '0,        1'b1, 1'b1, '0,        1'b1); // lone point again
        add_row(COORD_MIN, -24'sd1,   1'b0, 1'b0, '0,        1'b0); // full x span
        add_row(COORD_MAX, -24'sd1,   1'b1, 1'b1, 25'd16777215, 1'b0);
        add_row(24'sh555555, 24'shAAAAAA, 1'b0, 1'b0, '0,    1'b0); // bit patterns
        add_row(24'shAAAAAA, 24'sh555555, 1'b1, 1'b0, '0,    1'b0);

        foreach (directed_rows[r]) begin
            send_point(directed_rows[r].item, closes, res);
            if (closes) begin
                pending_distances.push_back(directed_rows[r].typed ? directed_rows[r].want
                                                                    : res);
            end
        end

        // random sets, many small, a few single or pairs
        random_sent = 0;
        while (random_sent < RANDOM_POINTS) begin
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    set_size = 1;
                end
                3, 4: begin
                    set_size = 2;
                end
                default: begin
                    set_size = $urandom_range(3, 16);
                end
            endcase
            cx = COORD_W'($urandom);
            cy = COORD_W'($urandom);
            for (k = 0; k < set_size; k++) begin
                it = rand_point(cx, cy, k == set_size - 1);
                send_point(it, closes, res);
                if (closes) begin
                    pending_distances.push_back(res);
                end
                random_sent++;
            end
        end

        // overrun the point store: the far point is not stored, so its repeat
        // is not compared with it; the last point lies next to the anchor
        for (k = 0; k < MAX_POINTS; k++) begin
            it.point_x    = COORD_W'($urandom);
            it.point_y    = COORD_W'($urandom);
            it.last_point = 1'b0;
            if (k == 7) begin
                anchor = it;
            end
            send_point(it, closes, res);
        end
        far_point.point_x    = COORD_W'($urandom);
        far_point.point_y    = COORD_W'($urandom);
        far_point.last_point = 1'b0;
        send_point(far_point, closes, res);
        send_point(far_point, closes, res);
        it.point_x    = COORD_W'(anchor.point_x + 3);
        it.point_y    = COORD_W'(anchor.point_y + 4);
        it.last_point = 1'b1;
        send_point(it, closes, res);
        if (closes) begin
            pending_distances.push_back(res);
        end

        in_valid <= 1'b0;
        while (pending_distances.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("** closest_pair_distance: PASSED **");
        end else begin
            $display("** closest_pair_distance: FAILED **");
        end
        $finish;
    end

endmodule
